FILE: hdl/assert_macros.svh
// Assertion helpers for clocked properties.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, skipped while reset is low.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/tod_pkg.sv
`default_nettype none

package tod_pkg;

    localparam int unsigned TENTHS_W  = 4;
    localparam int unsigned SECONDS_W = 7;
    localparam int unsigned MINUTES_W = 7;
    localparam int unsigned HOURS_W   = 8;
    localparam int unsigned PRESC_W   = 3;

    localparam int unsigned TIME_W    = TENTHS_W + SECONDS_W + MINUTES_W + HOURS_W;
    localparam int unsigned TDATA_W   = ((TIME_W + 7) / 8) * 8;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned APB_AW    = 5;

    // operation codes carried in tuser on the slave side
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_FIFTY_HZ  = 3'd0;
    localparam logic [2:0] REG_RUN       = 3'd1;
    localparam logic [2:0] REG_AL_TENTHS = 3'd2;
    localparam logic [2:0] REG_AL_SEC    = 3'd3;
    localparam logic [2:0] REG_AL_MIN    = 3'd4;
    localparam logic [2:0] REG_AL_HOURS  = 3'd5;

    localparam logic [HOURS_W-1:0]   HOURS_RESET  = 8'h01;
    localparam logic [PRESC_W-1:0]   LIMIT_50HZ   = 3'd4;
    localparam logic [PRESC_W-1:0]   LIMIT_60HZ   = 3'd5;
    localparam logic [TENTHS_W-1:0]  DIGIT_TEN    = 4'd10;
    localparam logic [2:0]           TENS_SIXTY   = 3'd6;
    localparam logic [4:0]           HOURS_THIRTEEN = 5'h13;
    localparam logic [4:0]           HOURS_TWELVE   = 5'h12;

    typedef struct packed {
        logic [HOURS_W-1:0]   hours;
        logic [MINUTES_W-1:0] minutes;
        logic [SECONDS_W-1:0] seconds;
        logic [TENTHS_W-1:0]  tenths;
    } t_time;

    typedef struct packed {
        logic [PRESC_W-1:0] prescale;
        t_time              tod;
    } t_state;

    typedef struct packed {
        logic  operation;
        t_time set;
    } t_item;

    typedef struct packed {
        logic                 fifty_hz;
        logic                 run;
        logic [TENTHS_W-1:0]  al_tenths;
        logic [SECONDS_W-1:0] al_seconds;
        logic [MINUTES_W-1:0] al_minutes;
        logic [HOURS_W-1:0]   al_hours;
    } t_cfg;

endpackage

`default_nettype wire

FILE: hdl/bcd_time_of_day_clock_core.sv
// Channel   | Dir | Handshake               | Payload
// s_axis    | in  | tvalid/tready           | tdata time to load, tuser operation
// m_axis    | out | tvalid/tready           | tdata time after beat, tuser alarm match
// apb       | in  | psel/penable/pwrite     | six registers at 4*index
//
// An input beat passes the input register, then goes through the step logic into
// the time/result register.
// One beat per cycle sustained while m_axis_tready is high; the time registers feed the next beat directly.
// A stalled result holds the step stage, which fills and then drops s_axis_tready.
// Synchronous reset: time 1 AM, prescaler 0, registers 0, both stages empty.
`default_nettype none
`include "assert_macros.svh"

module bcd_time_of_day_clock_core
    import tod_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // [3:0] set_tenths, [10:4] set_seconds, [17:11] set_minutes, [25:18] set_hours
    input  wire logic [TDATA_W-1:0] s_axis_tdata,
    // [0] operation
    input  wire logic [0:0]         s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [3:0] time_tenths, [10:4] time_seconds, [17:11] time_minutes, [25:18] time_hours
    output logic      [TDATA_W-1:0] m_axis_tdata,
    // [0] alarm_match
    output logic      [0:0]         m_axis_tuser,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [APB_AW-1:0]  paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic      [APB_DW-1:0]  prdata,
    output logic                    pready
);

    t_cfg   w_cfg;
    t_item  r_item;
    logic   r_in_valid;
    t_state r_state;
    t_state w_next;
    logic   w_match;
    logic   r_out_valid;
    logic   r_out_match;
    logic   w_adv;
    logic   w_in_take;

    tod_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tod_step u_step (
        .i_cfg   (w_cfg),
        .i_item  (r_item),
        .i_state (r_state),
        .o_state (w_next),
        .o_match (w_match)
    );

    // the step stage moves when the result slot is free or being drained
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item.operation <= s_axis_tuser[0];
            r_item.set       <= s_axis_tdata[TIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid         <= 1'b0;
            r_out_match         <= 1'b0;
            r_state.prescale    <= '0;
            r_state.tod.tenths  <= '0;
            r_state.tod.seconds <= '0;
            r_state.tod.minutes <= '0;
            r_state.tod.hours   <= HOURS_RESET;
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_out_match <= w_match;
                r_state     <= w_next;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // the live time is the result payload
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {{(TDATA_W-TIME_W){1'b0}}, r_state.tod};
    assign m_axis_tuser[0] = r_out_match;

    `ASSERT_CLK_RST(a_stall_holds_time, i_clk, i_rst_n,
        (r_out_valid && !m_axis_tready) |=> $stable(r_state), "time moved under stall")
    `ASSERT_CLK_RST(a_load_no_match, i_clk, i_rst_n,
        (w_adv && r_item.operation == OP_LOAD) |=> !r_out_match, "match on load")
    `ASSERT_CLK_RST(a_load_sets_time, i_clk, i_rst_n,
        (w_adv && r_item.operation == OP_LOAD) |=> (r_state.tod == $past(r_item.set)),
        "load did not set time")
    `ASSERT_CLK(a_ready_when_empty, i_clk,
        !s_axis_tready |-> r_in_valid, "stalled with empty input stage")

endmodule

`default_nettype wire

FILE: hdl/tod_cfg.sv
`default_nettype none

module tod_cfg
    import tod_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[APB_AW-1:2];
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_FIFTY_HZ:  n_cfg.fifty_hz   = pwdata[0];
                REG_RUN:       n_cfg.run        = pwdata[0];
                REG_AL_TENTHS: n_cfg.al_tenths  = pwdata[TENTHS_W-1:0];
                REG_AL_SEC:    n_cfg.al_seconds = pwdata[SECONDS_W-1:0];
                REG_AL_MIN:    n_cfg.al_minutes = pwdata[MINUTES_W-1:0];
                REG_AL_HOURS:  n_cfg.al_hours   = pwdata[HOURS_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_FIFTY_HZ:  prdata = {{(APB_DW-1){1'b0}}, r_cfg.fifty_hz};
            REG_RUN:       prdata = {{(APB_DW-1){1'b0}}, r_cfg.run};
            REG_AL_TENTHS: prdata = {{(APB_DW-TENTHS_W){1'b0}}, r_cfg.al_tenths};
            REG_AL_SEC:    prdata = {{(APB_DW-SECONDS_W){1'b0}}, r_cfg.al_seconds};
            REG_AL_MIN:    prdata = {{(APB_DW-MINUTES_W){1'b0}}, r_cfg.al_minutes};
            REG_AL_HOURS:  prdata = {{(APB_DW-HOURS_W){1'b0}}, r_cfg.al_hours};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: hdl/tod_step.sv
`default_nettype none

module tod_step
    import tod_pkg::*;
(
    input  wire t_cfg   i_cfg,
    input  wire t_item  i_item,
    input  wire t_state i_state,
    output t_state      o_state,
    output logic        o_match
);

    // returns {carry, field}; units wrap from ten to zero with a tens carry, tens of six wraps to zero
    function automatic logic [7:0] bump_sixty(input logic [6:0] field);
        logic [3:0] units;
        logic [2:0] tens;
        units = field[3:0] + 4'd1;
        tens  = field[6:4];
        if (units == DIGIT_TEN) begin
            units = '0;
            tens  = tens + 3'd1;
        end
        if (tens == TENS_SIXTY) begin
            bump_sixty = {1'b1, 7'd0};
        end else begin
            bump_sixty = {1'b0, tens, units};
        end
    endfunction

    function automatic logic [7:0] bump_hours(input logic [7:0] hrs);
        logic [3:0] units;
        logic       tens;
        logic [7:0] h;
        units = hrs[3:0] + 4'd1;
        tens  = hrs[4];
        if (!tens && units == DIGIT_TEN) begin
            units = '0;
            tens  = 1'b1;
        end
        h = {hrs[7], 2'b00, tens, units};
        if (h[4:0] == HOURS_THIRTEEN) begin
            h = {hrs[7], 7'd1};
        end else if (h[4:0] == HOURS_TWELVE) begin
            h[7] = ~h[7];
        end
        bump_hours = h;
    endfunction

    logic [PRESC_W-1:0] w_limit;
    logic [PRESC_W:0]   w_pre_inc;
    logic [7:0]         w_sec;
    logic [7:0]         w_min;
    logic [7:0]         w_hrs;
    logic [3:0]         w_tenths_inc;

    assign w_limit      = i_cfg.fifty_hz ? LIMIT_50HZ : LIMIT_60HZ;
    assign w_pre_inc    = {1'b0, i_state.prescale} + 4'd1;
    assign w_tenths_inc = i_state.tod.tenths + 4'd1;
    assign w_sec        = bump_sixty(i_state.tod.seconds);
    assign w_min        = bump_sixty(i_state.tod.minutes);
    assign w_hrs        = bump_hours(i_state.tod.hours);

    always_comb begin
        o_state = i_state;
        o_match = 1'b0;
        if (i_item.operation == OP_LOAD) begin
            o_state.tod = i_item.set;
        end else if (i_cfg.run) begin
            if (i_state.prescale != w_limit) begin
                // a count left high by a rate change wraps past five
                o_state.prescale = (w_pre_inc > 4'd5) ? '0 : w_pre_inc[PRESC_W-1:0];
            end else begin
                o_state.prescale   = '0;
                o_state.tod.tenths = w_tenths_inc;
                if (w_tenths_inc == DIGIT_TEN) begin
                    o_state.tod.tenths  = '0;
                    o_state.tod.seconds = w_sec[6:0];
                    if (w_sec[7]) begin
                        o_state.tod.minutes = w_min[6:0];
                        if (w_min[7]) begin
                            o_state.tod.hours = w_hrs;
                        end
                    end
                end
                o_match = (o_state.tod.tenths  == i_cfg.al_tenths)  &&
                          (o_state.tod.seconds == i_cfg.al_seconds) &&
                          (o_state.tod.minutes == i_cfg.al_minutes) &&
                          (o_state.tod.hours   == i_cfg.al_hours);
            end
        end
    end

endmodule

`default_nettype wire
